// ----- src/wts_pkg.sv -----
// types, constants and helpers shared by the world-to-screen projection block
// no dependencies
package wts_pkg;

  localparam int CoordW  = 24;
  localparam int CoefW   = 16;
  localparam int ProdW   = CoordW + CoefW;      // 40
  localparam int ClipW   = 43;
  localparam int SumW    = ClipW + 1;           // cx+cw, cw-cy
  localparam int DimW    = 14;
  localparam int ScaledW = SumW + DimW + 1;     // 59
  localparam int DivW    = 62;
  localparam int DenW    = ClipW + 1;           // 2*cw
  localparam int QuotW   = 16;
  localparam int QDepth  = 8;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int FracAlign = 20;

  // 10*cw >= 2^25 is cw >= 3355444
  localparam logic signed [ClipW-1:0] CwMin = 43'sd3355444;

  localparam logic [2:0] REG_X_COEF = 3'd0;
  localparam logic [2:0] REG_Y_COEF = 3'd1;
  localparam logic [2:0] REG_Z_COEF = 3'd2;
  localparam logic [2:0] REG_TRANS  = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  localparam int LaneX = 0;
  localparam int LaneY = 1;
  localparam int LaneW = 3;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
  } wts_in_t;

  typedef struct packed {
    logic                     in_front;
    logic signed [15:0]       screen_x;
    logic signed [15:0]       screen_y;
  } wts_out_t;

  typedef struct packed {
    logic [63:0]     x_coefficients;
    logic [63:0]     y_coefficients;
    logic [63:0]     z_coefficients;
    logic [63:0]     translation_terms;
    logic [DimW-1:0] screen_width;
    logic [DimW-1:0] screen_height;
  } wts_cfg_t;

  typedef struct packed {
    logic                    in_front;
    logic signed [SumW-1:0]  sum_x;
    logic signed [SumW-1:0]  sum_y;
    logic signed [ClipW-1:0] cw;
  } wts_qent_t;

  function automatic logic signed [CoefW-1:0] lane(input logic [63:0] r, input int k);
    lane = $signed(r[CoefW*k +: CoefW]);
  endfunction

endpackage

// ----- src/world_to_screen_projection.sv -----
// top level of the world-to-screen projection block: config registers and wiring
// depends on wts_pkg, wts_front, wts_queue, wts_back
//
// Projects one world point per clock: start is taken whenever busy is low, and every
// point gives exactly one result, shown on out_data for one cycle with out_valid high.
// The receiver cannot stall. A front pipeline of three stages forms clip coordinates
// and the in-front test and feeds a short fifo; the back end scales by the viewport
// size and divides by 2*cw with one quotient bit per stage over a 16-stage divider,
// so throughput is one point per cycle. busy rises only if the fifo nears full.
// Configuration writes are always ready and take effect at once.
module world_to_screen_projection import wts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  wts_in_t     in_data,
  output logic        out_valid,
  output wts_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  wts_cfg_t  cfg_r;
  wts_qent_t ent, q_data;
  logic      ent_valid, q_empty, q_afull, accept;

  assign cfg_ready = 1'b1;
  assign busy      = q_afull;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_coefficients    <= '0;
      cfg_r.y_coefficients    <= '0;
      cfg_r.z_coefficients    <= '0;
      cfg_r.translation_terms <= '0;
      cfg_r.screen_width      <= DimW'(1920);
      cfg_r.screen_height     <= DimW'(1080);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_COEF: cfg_r.x_coefficients    <= cfg_data;
        REG_Y_COEF: cfg_r.y_coefficients    <= cfg_data;
        REG_Z_COEF: cfg_r.z_coefficients    <= cfg_data;
        REG_TRANS:  cfg_r.translation_terms <= cfg_data;
        REG_WIDTH:  cfg_r.screen_width      <= cfg_data[DimW-1:0];
        REG_HEIGHT: cfg_r.screen_height     <= cfg_data[DimW-1:0];
        default: ;
      endcase
    end
  end

  wts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .ent_valid (ent_valid),
    .ent       (ent)
  );

  wts_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (ent_valid),
    .push_data   (ent),
    .pop         (!q_empty),
    .pop_data    (q_data),
    .empty       (q_empty),
    .almost_full (q_afull)
  );

  wts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (!q_empty),
    .ent       (q_data),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- src/wts_front.sv -----
// front end: matrix multiply to clip coordinates and the in-front test
// depends on wts_pkg
module wts_front import wts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  wts_in_t   in_data,
  input  wts_cfg_t  cfg,
  output logic      ent_valid,
  output wts_qent_t ent
);

  logic signed [ProdW-1:0] prod_r [3][3];   // [lane][coord]
  logic signed [ProdW-1:0] prod_nxt [3][3];
  logic signed [ClipW-1:0] clip_r [3];
  logic signed [ClipW-1:0] clip_nxt [3];
  logic                    v1_r, v2_r, v3_r;
  wts_qent_t               ent_r, ent_nxt;

  always_comb begin
    int ln;
    for (int k = 0; k < 3; k++) begin
      ln = (k == 2) ? LaneW : k;
      prod_nxt[k][0] = in_data.pos_x * lane(cfg.x_coefficients, ln);
      prod_nxt[k][1] = in_data.pos_y * lane(cfg.y_coefficients, ln);
      prod_nxt[k][2] = in_data.pos_z * lane(cfg.z_coefficients, ln);
    end
  end

  always_comb begin
    int ln;
    for (int k = 0; k < 3; k++) begin
      ln = (k == 2) ? LaneW : k;
      clip_nxt[k] = ClipW'(prod_r[k][0]) + ClipW'(prod_r[k][1]) + ClipW'(prod_r[k][2])
                  + (ClipW'(lane(cfg.translation_terms, ln)) <<< FracAlign);
    end
  end

  always_comb begin
    ent_nxt.in_front = (clip_r[2] >= CwMin);
    ent_nxt.sum_x    = SumW'(clip_r[0]) + SumW'(clip_r[2]);
    ent_nxt.sum_y    = SumW'(clip_r[2]) - SumW'(clip_r[1]);
    ent_nxt.cw       = clip_r[2];
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    clip_r <= clip_nxt;
    ent_r  <= ent_nxt;
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign ent_valid = v3_r;
  assign ent       = ent_r;

endmodule

// ----- src/wts_queue.sv -----
// short fifo between the front and back ends, flop based
// depends on wts_pkg
module wts_queue import wts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  wts_qent_t push_data,
  input  logic      pop,
  output wts_qent_t pop_data,
  output logic      empty,
  output logic      almost_full
);

  wts_qent_t        mem_r [QDepth];
  logic [QPtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPtrW:0]   cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  // leaves room for the items still in the front pipeline
  assign almost_full = (cnt_r > (QPtrW+1)'(QDepth - 4));
  assign pop_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/wts_back.sv -----
// back end: viewport scale, pipelined rounding divide by 2*cw, saturation
// depends on wts_pkg
module wts_back import wts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      ent_valid,
  input  wts_qent_t ent,
  input  wts_cfg_t  cfg,
  output logic      out_valid,
  output wts_out_t  out_data
);

  localparam int NSt = QuotW + 1;

  // scale stage
  logic                      s1v_r;
  logic                      s1f_r;
  logic signed [ScaledW-1:0] mx_r, my_r, mx_nxt, my_nxt;
  logic signed [ClipW-1:0]   s1cw_r;
  // offset dividend stage
  logic                      s2v_r, s2f_r;
  logic signed [DivW-1:0]    nx_r, ny_r, nx_nxt, ny_nxt;
  logic [DenW-1:0]           s2d_r;
  // divider stages
  logic                      dv_r [NSt];
  logic                      df_r [NSt];
  logic [1:0]                satx_r [NSt];   // {low, high}
  logic [1:0]                saty_r [NSt];
  logic [DivW-2:0]           remx_r [NSt];
  logic [DivW-2:0]           remy_r [NSt];
  logic [QuotW-1:0]          qx_r [NSt];
  logic [QuotW-1:0]          qy_r [NSt];
  logic [DenW-1:0]           dd_r [NSt];
  logic [DivW-2:0]           remx_nxt [NSt];
  logic [DivW-2:0]           remy_nxt [NSt];
  logic [QuotW-1:0]          qx_nxt [NSt];
  logic [QuotW-1:0]          qy_nxt [NSt];
  logic [DivW-1:0]           big_lim;
  wts_out_t                  out_r, out_nxt;
  logic                      ov_r;

  assign mx_nxt = ent.sum_x * $signed({1'b0, cfg.screen_width});
  assign my_nxt = ent.sum_y * $signed({1'b0, cfg.screen_height});

  // n = scaled + cw, then offset by 2^15 * (2*cw) so the quotient is unsigned
  assign nx_nxt = DivW'(mx_r) + DivW'(s1cw_r) + (DivW'(s1cw_r) <<< 16);
  assign ny_nxt = DivW'(my_r) + DivW'(s1cw_r) + (DivW'(s1cw_r) <<< 16);
  assign big_lim = DivW'(s2d_r) << 16;

  always_comb begin
    logic [DivW-1:0] dsh;
    logic [DivW-1:0] tx, ty;
    for (int s = 0; s < NSt; s++) begin
      remx_nxt[s] = remx_r[s];
      remy_nxt[s] = remy_r[s];
      qx_nxt[s]   = qx_r[s];
      qy_nxt[s]   = qy_r[s];
    end
    for (int s = 0; s < NSt - 1; s++) begin
      dsh = DivW'(dd_r[s]) << (QuotW - 1 - s);
      tx  = {1'b0, remx_r[s]} - dsh;
      ty  = {1'b0, remy_r[s]} - dsh;
      if (!tx[DivW-1]) begin
        remx_nxt[s] = tx[DivW-2:0];
        qx_nxt[s][QuotW-1-s] = 1'b1;
      end
      if (!ty[DivW-1]) begin
        remy_nxt[s] = ty[DivW-2:0];
        qy_nxt[s][QuotW-1-s] = 1'b1;
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    if (df_r[NSt-1]) begin
      out_nxt.in_front = 1'b1;
      case (satx_r[NSt-1])
        2'b10:   out_nxt.screen_x = 16'sh8000;
        2'b01:   out_nxt.screen_x = 16'sh7fff;
        default: out_nxt.screen_x = $signed(qx_r[NSt-1] ^ 16'h8000);
      endcase
      case (saty_r[NSt-1])
        2'b10:   out_nxt.screen_y = 16'sh8000;
        2'b01:   out_nxt.screen_y = 16'sh7fff;
        default: out_nxt.screen_y = $signed(qy_r[NSt-1] ^ 16'h8000);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    s1f_r  <= ent.in_front;
    s1cw_r <= ent.cw;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    s2f_r  <= s1f_r;
    s2d_r  <= {s1cw_r, 1'b0};
    // entry stage of the divider
    df_r[0]   <= s2f_r;
    dd_r[0]   <= s2d_r;
    satx_r[0] <= {nx_r[DivW-1], !nx_r[DivW-1] && ($unsigned(nx_r) >= big_lim)};
    saty_r[0] <= {ny_r[DivW-1], !ny_r[DivW-1] && ($unsigned(ny_r) >= big_lim)};
    remx_r[0] <= nx_r[DivW-2:0];
    remy_r[0] <= ny_r[DivW-2:0];
    qx_r[0]   <= '0;
    qy_r[0]   <= '0;
    for (int s = 1; s < NSt; s++) begin
      df_r[s]   <= df_r[s-1];
      dd_r[s]   <= dd_r[s-1];
      satx_r[s] <= satx_r[s-1];
      saty_r[s] <= saty_r[s-1];
      remx_r[s] <= remx_nxt[s-1];
      remy_r[s] <= remy_nxt[s-1];
      qx_r[s]   <= qx_nxt[s-1];
      qy_r[s]   <= qy_nxt[s-1];
    end
    out_r <= out_nxt;
    if (!rst_n) begin
      s1v_r <= 1'b0;
      s2v_r <= 1'b0;
      for (int s = 0; s < NSt; s++) begin
        dv_r[s] <= 1'b0;
      end
      ov_r <= 1'b0;
    end else begin
      s1v_r <= ent_valid;
      s2v_r <= s1v_r;
      dv_r[0] <= s2v_r;
      for (int s = 1; s < NSt; s++) begin
        dv_r[s] <= dv_r[s-1];
      end
      ov_r <= dv_r[NSt-1];
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the world-to-screen projection block
// depends on wts_pkg and world_to_screen_projection; predicts pixels by model or row table
`timescale 1ns / 1ps

module testbench;
  import wts_pkg::*;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     identity_cfg;
    logic                     typed;
    wts_out_t                 exp;
  } dir_row_t;

  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 40;
  localparam int RandomPhases  = 8;
  localparam int PhaseItems    = 190;
  localparam logic signed [CoordW-1:0] PosMax = 24'sh7fffff;
  localparam logic signed [CoordW-1:0] PosMin = 24'sh800000;
  localparam wts_out_t Behind = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  wts_in_t     in_data = '0;
  logic        out_valid;
  wts_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] view_regs [6];
  wts_out_t    pixel_fifo [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          sender_idle_pct = 0;

  dir_row_t dir_rows [18] = '{
    '{24'sd0,  24'sd0,  24'sd0,  1'b0, 1'b1, Behind},
    '{PosMax,  PosMax,  PosMax,  1'b0, 1'b1, Behind},
    '{PosMin,  PosMin,  PosMin,  1'b0, 1'b1, Behind},
    '{PosMax,  PosMin,  24'sd0,  1'b0, 1'b1, Behind},
    '{-24'sd1, 24'sd1,  -24'sd1, 1'b0, 1'b1, Behind},
    '{24'sd0,  24'sd0,  24'sd0,  1'b1, 1'b0, Behind},
    '{24'sd4096, 24'sd4096, 24'sd0, 1'b1, 1'b0, Behind},
    '{-24'sd4096, -24'sd4096, 24'sd0, 1'b1, 1'b0, Behind},
    '{24'sd2048, -24'sd2048, 24'sd0, 1'b1, 1'b0, Behind},
    '{PosMax,  PosMax,  24'sd0,  1'b1, 1'b0, Behind},
    '{PosMin,  PosMin,  24'sd0,  1'b1, 1'b0, Behind},
    '{24'sd100, 24'sd100, -24'sd4096, 1'b1, 1'b0, Behind},
    '{24'sd0,  24'sd0,  24'sd4096, 1'b1, 1'b0, Behind},
    '{24'sd0,  24'sd0,  PosMax,  1'b1, 1'b0, Behind},
    '{24'sd4096, 24'sd0, PosMin, 1'b1, 1'b0, Behind},
    '{24'sd0,  24'sd0,  24'sd3686, 1'b1, 1'b0, Behind},
    '{24'sd0,  24'sd0,  24'sd3687, 1'b1, 1'b0, Behind},
    '{24'sd1,  -24'sd1, 24'sd1,   1'b1, 1'b0, Behind}
  };

  world_to_screen_projection i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint coef_lane(input logic [63:0] r, input int k);
    logic signed [15:0] v;
    v = r[16*k +: 16];
    return longint'(v);
  endfunction

  // round half up of num/den, den > 0, clamped to 16 bits
  function automatic logic [15:0] round_to_pixel(input longint num, input longint den);
    longint n;
    longint d;
    longint q;
    n = 2 * num + den;
    d = 2 * den;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    if (q < -32768) q = -32768;
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  function automatic wts_out_t project_point(input wts_in_t p);
    longint   clip [4];
    longint   w_px;
    longint   h_px;
    wts_out_t r;
    for (int k = 0; k < 4; k++) begin
      clip[k] = longint'(p.pos_x) * coef_lane(view_regs[REG_X_COEF], k)
              + longint'(p.pos_y) * coef_lane(view_regs[REG_Y_COEF], k)
              + longint'(p.pos_z) * coef_lane(view_regs[REG_Z_COEF], k)
              + coef_lane(view_regs[REG_TRANS], k) * (64'sd1 << FracAlign);
    end
    r = '0;
    if (clip[3] * 10 >= (64'sd1 << 25)) begin
      w_px = longint'(view_regs[REG_WIDTH][DimW-1:0]);
      h_px = longint'(view_regs[REG_HEIGHT][DimW-1:0]);
      r.in_front = 1'b1;
      r.screen_x = round_to_pixel(w_px * (clip[0] + clip[3]), 2 * clip[3]);
      r.screen_y = round_to_pixel(h_px * (clip[3] - clip[1]), 2 * clip[3]);
    end
    return r;
  endfunction

  // valid stays high between back-to-back writes; the caller drops it
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_HEIGHT) view_regs[idx] = val;
  endtask

  task automatic load_view(input logic [63:0] xc, input logic [63:0] yc, input logic [63:0] zc,
                           input logic [63:0] tr, input logic [63:0] wd, input logic [63:0] ht);
    write_reg(REG_X_COEF, xc);
    write_reg(REG_Y_COEF, yc);
    write_reg(REG_Z_COEF, zc);
    write_reg(REG_TRANS, tr);
    write_reg(REG_WIDTH, wd);
    write_reg(REG_HEIGHT, ht);
    // indexes past the last register must be ignored
    write_reg(3'($urandom_range(6, 7)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pixel_fifo.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // one point per call; start stays high into the next call unless a gap is drawn
  task automatic send_point(input wts_in_t p, input logic typed, input wts_out_t exp);
    start   <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (busy);
    pixel_fifo.push_back(typed ? exp : project_point(p));
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      in_data <= '0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return CoordW'($signed($urandom_range(131071)) - 65536);
    if (sel < 85) return CoordW'($urandom);
    case ($urandom_range(4))
      0: return PosMax;
      1: return PosMin;
      2: return '0;
      3: return -24'sd1;
      default: return 24'sd1;
    endcase
  endfunction

  // other lanes sometimes modest, clip w lane mostly kept small so many points land in front
  function automatic logic [63:0] rand_coefs();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(3) != 0) r[63:48] = 16'($signed($urandom_range(512)) - 256);
    if ($urandom_range(3) == 0) r[47:0] = {3{16'($signed($urandom_range(16384)) - 8192)}};
    return r;
  endfunction

  function automatic logic [63:0] rand_dim();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'd8192;
      3: return 64'h3fff;
      4: return {$urandom, $urandom};
      default: return 64'($urandom_range(1, 4096));
    endcase
  endfunction

  always @(posedge clk) begin
    wts_out_t want;
    if (rst_n && out_valid) begin
      if (pixel_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pixel_fifo.pop_front();
        if (out_data.in_front !== want.in_front || out_data.screen_x !== want.screen_x ||
            out_data.screen_y !== want.screen_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    wts_in_t     p;
    logic [63:0] trans;
    view_regs[REG_X_COEF] = '0;
    view_regs[REG_Y_COEF] = '0;
    view_regs[REG_Z_COEF] = '0;
    view_regs[REG_TRANS]  = '0;
    view_regs[REG_WIDTH]  = 64'd1920;
    view_regs[REG_HEIGHT] = 64'd1080;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: reset view first (everything behind), then a unit view
    foreach (dir_rows[i]) begin
      if (dir_rows[i].identity_cfg && !dir_rows[i-1].identity_cfg) begin
        start <= 1'b0;
        wait_idle();
        // cw = 1 - z, so positive z walks through the near plane
        load_view(64'h0000_0000_0000_2000, 64'h0000_0000_2000_0000,
                  64'he000_2000_0000_0000, 64'h0020_0000_0000_0000, 64'd1920, 64'd1080);
      end
      p.pos_x = dir_rows[i].x;
      p.pos_y = dir_rows[i].y;
      p.pos_z = dir_rows[i].z;
      send_point(p, dir_rows[i].typed, dir_rows[i].exp);
    end

    for (int ph = 0; ph < RandomPhases; ph++) begin
      start <= 1'b0;
      wait_idle();
      case (ph)
        2: load_view('1, '1, '1, '1, 64'h3fff, 64'h3fff);
        4: load_view(64'h8000_8000_8000_8000, 64'h7fff_7fff_7fff_7fff,
                     64'h8000_7fff_8000_7fff, 64'h7fff_8000_7fff_8000, 64'd1, 64'd8192);
        6: load_view(rand_coefs(), rand_coefs(), rand_coefs(),
                     64'h0020_0000_0000_0000, 64'd0, 64'd0);
        default: begin
          trans = {$urandom, $urandom};
          trans[63:48] = 16'($urandom_range(1, 32767));
          load_view(rand_coefs(), rand_coefs(), rand_coefs(), trans, rand_dim(), rand_dim());
        end
      endcase
      case (ph % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 66;
        2: sender_idle_pct = 0;
        default: sender_idle_pct = 31;
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        p.pos_x = rand_coord();
        p.pos_y = rand_coord();
        p.pos_z = rand_coord();
        send_point(p, 1'b0, Behind);
      end
    end

    start <= 1'b0;
    in_data <= '0;
    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
